### src/qsr_pkg.sv
// Shared types, constants and saturating arithmetic for the quartic secant root finder.
`timescale 1ns / 1ps
package qsr_pkg;

  localparam int WORD_BITS    = 64;
  localparam int FRAC_BITS    = 32;
  localparam int HALF_BITS    = WORD_BITS / 2;
  localparam int ITER_BITS    = 8;
  localparam int CFG_IDX_BITS = 8;
  localparam int NUM_COEFS    = 5;
  localparam int COEF_IDX_BITS = 3;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [WORD_BITS-1:0]        uword_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_QUARTIC  = 8'd0;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_CUBIC    = 8'd1;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_SQUARE   = 8'd2;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_LINEAR   = 8'd3;
  localparam logic [CFG_IDX_BITS-1:0] CFG_COEF_CONSTANT = 8'd4;
  localparam logic [CFG_IDX_BITS-1:0] CFG_TOLERANCE     = 8'd5;
  localparam logic [CFG_IDX_BITS-1:0] CFG_STEP_DELTA    = 8'd6;
  localparam logic [CFG_IDX_BITS-1:0] CFG_ITER_LIMIT    = 8'd7;

  // Reset values of the configuration registers
  localparam word_t RST_COEF_QUARTIC  = 64'sd4294967296;
  localparam word_t RST_COEF_CUBIC    = -64'sd33925946671;
  localparam word_t RST_COEF_SQUARE   = 64'sd99991623245;
  localparam word_t RST_COEF_LINEAR   = -64'sd130286465065;
  localparam word_t RST_COEF_CONSTANT = 64'sd63302064197;
  localparam logic [WORD_BITS-2:0] RST_TOLERANCE  = 63'd4295;
  localparam logic [WORD_BITS-2:0] RST_STEP_DELTA = 63'd429496730;
  localparam logic [ITER_BITS-1:0] RST_ITER_LIMIT = 8'd64;

  // Result status codes
  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_ZERO_DEN  = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;
  localparam logic [1:0] ST_OVERFLOW  = 2'd3;

  // Polynomial evaluation points
  localparam logic [1:0] SRC_X1 = 2'd0;
  localparam logic [1:0] SRC_X0 = 2'd1;
  localparam logic [1:0] SRC_XP = 2'd2;
  localparam logic [1:0] SRC_XM = 2'd3;

  // Function value slots
  localparam logic [1:0] SLOT_NONE = 2'd0;
  localparam logic [1:0] SLOT_FA   = 2'd1;
  localparam logic [1:0] SLOT_FB   = 2'd2;
  localparam logic [1:0] SLOT_FC   = 2'd3;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_ITER,
    CMD_PSTART,
    CMD_MUL_START,
    CMD_MULQ,
    CMD_HORNER,
    CMD_STORE,
    CMD_DIFF,
    CMD_NUM_START,
    CMD_DIV_START,
    CMD_STEP,
    CMD_UPDATE
  } cmd_e;

  typedef struct packed {
    cmd_e                     op;
    logic [1:0]               src;
    logic [COEF_IDX_BITS-1:0] coef_k;
    logic [1:0]               slot;
  } dp_cmd_t;

  typedef struct packed {
    logic                 ov;
    logic                 den_zero;
    logic                 conv;
    logic                 mul_busy;
    logic                 div_busy;
    logic                 modified;
    logic [ITER_BITS-1:0] limit;
  } dp_stat_t;

  // Magnitude of a two's complement word
  function automatic uword_t mag(input word_t a);
    mag = a[WORD_BITS-1] ? (~a + 1'b1) : a;
  endfunction

  // Saturating add, overflow flag in the top bit
  function automatic logic [WORD_BITS:0] sat_add(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} + {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_add = {1'b1, s[WORD_BITS] ? WORD_MIN : WORD_MAX};
    end else begin
      sat_add = {1'b0, s[WORD_BITS-1:0]};
    end
  endfunction

  // Saturating subtract, overflow flag in the top bit
  function automatic logic [WORD_BITS:0] sat_sub(input word_t a, input word_t b);
    logic [WORD_BITS:0] s;
    s = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    if (s[WORD_BITS] != s[WORD_BITS-1]) begin
      sat_sub = {1'b1, s[WORD_BITS] ? WORD_MIN : WORD_MAX};
    end else begin
      sat_sub = {1'b0, s[WORD_BITS-1:0]};
    end
  endfunction

  // Signed word from sign and magnitude, saturating
  function automatic logic [WORD_BITS:0] from_mag(input logic neg, input uword_t m);
    if (!neg) begin
      from_mag = m[WORD_BITS-1] ? {1'b1, WORD_MAX} : {1'b0, m};
    end else if (m > uword_t'(WORD_MIN)) begin
      from_mag = {1'b1, WORD_MIN};
    end else begin
      from_mag = {1'b0, ~m + 1'b1};
    end
  endfunction

endpackage

### src/qsr_if.sv
// Request, result and configuration channel interfaces.
`timescale 1ns / 1ps
interface qsr_req_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  qsr_pkg::word_t       start_a;
  qsr_pkg::word_t       start_b;
  modport source (output valid, opcode, start_a, start_b, input ready);
  modport sink   (input valid, opcode, start_a, start_b, output ready);
endinterface

interface qsr_res_if;
  logic                             valid;
  logic                             ready;
  qsr_pkg::word_t                   root;
  qsr_pkg::word_t                   residual;
  logic [qsr_pkg::ITER_BITS-1:0]    iterations;
  logic [1:0]                       status;
  modport source (output valid, root, residual, iterations, status, input ready);
  modport sink   (input valid, root, residual, iterations, status, output ready);
endinterface

interface qsr_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qsr_pkg::CFG_IDX_BITS-1:0]  index;
  qsr_pkg::uword_t                   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/qsr_mul.sv
// Multi-cycle 64 x 64 unsigned multiplier built on one 32 x 32 partial product.
`timescale 1ns / 1ps
module qsr_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  qsr_pkg::uword_t             a_i,
  input  qsr_pkg::uword_t             b_i,
  output logic                        busy_o,
  output logic [2*qsr_pkg::WORD_BITS-1:0] prod_o
);
  import qsr_pkg::*;

  localparam int PW = 2 * WORD_BITS;

  logic                 busy_q, busy_d;
  logic [1:0]           cnt_q, cnt_d;
  uword_t               a_q, b_q;
  logic [PW-1:0]        acc_q, acc_d;
  logic [HALF_BITS-1:0] op_a, op_b;
  logic [WORD_BITS-1:0] pp;
  logic [PW-1:0]        pp_sh;

  // Operand halves for this step
  always_comb begin
    op_a  = cnt_q[0] ? a_q[WORD_BITS-1:HALF_BITS] : a_q[HALF_BITS-1:0];
    op_b  = cnt_q[1] ? b_q[WORD_BITS-1:HALF_BITS] : b_q[HALF_BITS-1:0];
    pp    = op_a * op_b;
    case (cnt_q)
      2'd0:    pp_sh = {{WORD_BITS{1'b0}}, pp};
      2'd3:    pp_sh = {pp, {WORD_BITS{1'b0}}};
      default: pp_sh = {{HALF_BITS{1'b0}}, pp, {HALF_BITS{1'b0}}};
    endcase
  end

  // Step control and accumulation
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    acc_d  = acc_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = 2'd0;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + pp_sh;
      cnt_d = cnt_q + 2'd1;
      if (cnt_q == 2'd3) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
    end
  end

  assign busy_o = busy_q;
  assign prod_o = acc_q;

endmodule

### src/qsr_div.sv
// Restoring divider: double-width dividend by a word, one quotient bit per cycle.
`timescale 1ns / 1ps
module qsr_div (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  qsr_pkg::uword_t hi_i,
  input  qsr_pkg::uword_t lo_i,
  input  qsr_pkg::uword_t den_i,
  output logic            busy_o,
  output logic            ovf_o,
  output qsr_pkg::uword_t quo_o
);
  import qsr_pkg::*;

  localparam int CW = $clog2(WORD_BITS);

  logic            busy_q, busy_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            ovf_q;
  uword_t          r_q, r_d, lo_q, lo_d, q_q, q_d, d_q;
  uword_t          r_sh;
  logic            carry;

  // One shift-subtract step
  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    r_d    = r_q;
    lo_d   = lo_q;
    q_d    = q_q;
    carry  = r_q[WORD_BITS-1];
    r_sh   = {r_q[WORD_BITS-2:0], lo_q[WORD_BITS-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = hi_i;
      lo_d   = lo_i;
      q_d    = '0;
    end else if (busy_q) begin
      lo_d = {lo_q[WORD_BITS-2:0], 1'b0};
      if (carry || (r_sh >= d_q)) begin
        r_d = r_sh - d_q;
        q_d = {q_q[WORD_BITS-2:0], 1'b1};
      end else begin
        r_d = r_sh;
        q_d = {q_q[WORD_BITS-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CW'(WORD_BITS - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    lo_q <= lo_d;
    q_q  <= q_d;
    if (start_i) begin
      d_q   <= den_i;
      ovf_q <= (hi_i >= den_i);
    end
  end

  assign busy_o = busy_q;
  assign ovf_o  = ovf_q;
  assign quo_o  = q_q;

endmodule

### src/qsr_dp.sv
// Datapath: configuration registers, iterates, Horner evaluation and the secant update.
`timescale 1ns / 1ps
module qsr_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [qsr_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  qsr_pkg::uword_t                    cfg_data_i,
  input  logic                               opcode_i,
  input  qsr_pkg::word_t                     start_a_i,
  input  qsr_pkg::word_t                     start_b_i,
  input  qsr_pkg::dp_cmd_t                   cmd_i,
  output qsr_pkg::dp_stat_t                  stat_o,
  output qsr_pkg::word_t                     root_o,
  output qsr_pkg::word_t                     residual_o
);
  import qsr_pkg::*;

  // Configuration
  word_t                 coef_q [NUM_COEFS];
  logic [WORD_BITS-2:0]  tol_q, dsig_q;
  logic [ITER_BITS-1:0]  limit_q;

  // Working registers
  logic  mode_q, ov_q, mneg_q, nneg_q, qneg_q;
  word_t x0_q, x1_q, xe_q, p_q, mq_q, fa_q, fb_q, fc_q, d_q, den_q, step_q;

  // Units
  logic                    mul_start, mul_busy, div_start, div_busy, div_ovf;
  uword_t                  mul_a, mul_b, quo;
  logic [2*WORD_BITS-1:0]  prod;

  word_t                   dsig_w;
  logic [WORD_BITS:0]      r_xe, r_mulq, r_horn, r_d, r_den, r_step, r_x2;
  uword_t                  q_trunc;
  logic                    q_inc;

  assign dsig_w = {1'b0, dsig_q};

  qsr_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .busy_o  (mul_busy),
    .prod_o  (prod)
  );

  qsr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .hi_i    (prod[2*WORD_BITS-1:WORD_BITS]),
    .lo_i    (prod[WORD_BITS-1:0]),
    .den_i   (mag(den_q)),
    .busy_o  (div_busy),
    .ovf_o   (div_ovf),
    .quo_o   (quo)
  );

  // Multiplier operand selection
  always_comb begin
    mul_start = (cmd_i.op == CMD_MUL_START) || (cmd_i.op == CMD_NUM_START);
    div_start = (cmd_i.op == CMD_DIV_START);
    if (cmd_i.op == CMD_NUM_START) begin
      mul_a = mag(fa_q);
      mul_b = mode_q ? {dsig_q, 1'b0} : mag(d_q);
    end else begin
      mul_a = mag(p_q);
      mul_b = mag(xe_q);
    end
  end

  // Arithmetic for each command
  always_comb begin
    case (cmd_i.src)
      SRC_X1:  r_xe = {1'b0, x1_q};
      SRC_X0:  r_xe = {1'b0, x0_q};
      SRC_XP:  r_xe = sat_add(x1_q, dsig_w);
      default: r_xe = sat_sub(x1_q, dsig_w);
    endcase

    // Product scaled back by FRAC_BITS, rounded toward minus infinity
    q_trunc = prod[FRAC_BITS +: WORD_BITS];
    q_inc   = mneg_q && (|prod[FRAC_BITS-1:0]);
    if (|prod[2*WORD_BITS-1:WORD_BITS+FRAC_BITS]) begin
      r_mulq = {1'b1, mneg_q ? WORD_MIN : WORD_MAX};
    end else if (q_inc && (&q_trunc)) begin
      r_mulq = {1'b1, WORD_MIN};
    end else begin
      r_mulq = from_mag(mneg_q, q_trunc + {{(WORD_BITS-1){1'b0}}, q_inc});
    end

    r_horn = sat_add(mq_q, coef_q[cmd_i.coef_k]);
    r_d    = sat_sub(x1_q, x0_q);
    r_den  = mode_q ? sat_sub(fb_q, fc_q) : sat_sub(fa_q, fb_q);
    r_step = div_ovf ? {1'b1, qneg_q ? WORD_MIN : WORD_MAX} : from_mag(qneg_q, quo);
    r_x2   = sat_sub(x1_q, step_q);
  end

  // Control registers: configuration and the overflow flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q[0] <= RST_COEF_QUARTIC;
      coef_q[1] <= RST_COEF_CUBIC;
      coef_q[2] <= RST_COEF_SQUARE;
      coef_q[3] <= RST_COEF_LINEAR;
      coef_q[4] <= RST_COEF_CONSTANT;
      tol_q     <= RST_TOLERANCE;
      dsig_q    <= RST_STEP_DELTA;
      limit_q   <= RST_ITER_LIMIT;
      ov_q      <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_COEF_QUARTIC:  coef_q[0] <= cfg_data_i;
          CFG_COEF_CUBIC:    coef_q[1] <= cfg_data_i;
          CFG_COEF_SQUARE:   coef_q[2] <= cfg_data_i;
          CFG_COEF_LINEAR:   coef_q[3] <= cfg_data_i;
          CFG_COEF_CONSTANT: coef_q[4] <= cfg_data_i;
          CFG_TOLERANCE:     tol_q     <= cfg_data_i[WORD_BITS-2:0];
          CFG_STEP_DELTA:    dsig_q    <= cfg_data_i[WORD_BITS-2:0];
          CFG_ITER_LIMIT:    limit_q   <= cfg_data_i[ITER_BITS-1:0];
          default: ;
        endcase
      end
      case (cmd_i.op)
        CMD_LOAD, CMD_ITER: ov_q <= 1'b0;
        CMD_PSTART:         ov_q <= ov_q | r_xe[WORD_BITS];
        CMD_MULQ:           ov_q <= ov_q | r_mulq[WORD_BITS];
        CMD_HORNER:         ov_q <= ov_q | r_horn[WORD_BITS];
        CMD_DIFF:           ov_q <= ov_q | r_den[WORD_BITS] | (!mode_q & r_d[WORD_BITS]);
        CMD_STEP:           ov_q <= ov_q | r_step[WORD_BITS];
        CMD_UPDATE:         ov_q <= ov_q | r_x2[WORD_BITS];
        default: ;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      CMD_LOAD: begin
        mode_q <= opcode_i;
        x0_q   <= start_a_i;
        x1_q   <= start_b_i;
      end
      CMD_PSTART: begin
        xe_q <= r_xe[WORD_BITS-1:0];
        p_q  <= coef_q[0];
      end
      CMD_MUL_START: mneg_q <= p_q[WORD_BITS-1] ^ xe_q[WORD_BITS-1];
      CMD_MULQ:      mq_q   <= r_mulq[WORD_BITS-1:0];
      CMD_HORNER:    p_q    <= r_horn[WORD_BITS-1:0];
      CMD_STORE: begin
        case (cmd_i.slot)
          SLOT_FA: fa_q <= p_q;
          SLOT_FB: fb_q <= p_q;
          SLOT_FC: fc_q <= p_q;
          default: ;
        endcase
      end
      CMD_DIFF: begin
        d_q   <= r_d[WORD_BITS-1:0];
        den_q <= r_den[WORD_BITS-1:0];
      end
      CMD_NUM_START: nneg_q <= mode_q ? fa_q[WORD_BITS-1]
                                      : (fa_q[WORD_BITS-1] ^ d_q[WORD_BITS-1]);
      CMD_DIV_START: qneg_q <= nneg_q ^ den_q[WORD_BITS-1];
      CMD_STEP:      step_q <= r_step[WORD_BITS-1:0];
      CMD_UPDATE: begin
        if (!(ov_q || r_x2[WORD_BITS])) begin
          x0_q <= x1_q;
          x1_q <= r_x2[WORD_BITS-1:0];
        end
      end
      default: ;
    endcase
  end

  // Status towards the controller
  always_comb begin
    stat_o.ov       = ov_q;
    stat_o.den_zero = (den_q == '0);
    stat_o.conv     = (mag(step_q) <= {1'b0, tol_q});
    stat_o.mul_busy = mul_busy;
    stat_o.div_busy = div_busy;
    stat_o.modified = mode_q;
    stat_o.limit    = limit_q;
  end

  assign root_o     = x1_q;
  assign residual_o = p_q;

endmodule

### src/qsr_ctrl.sv
// Controller: sequences polynomial evaluations, the update and the result hand-off.
`timescale 1ns / 1ps
module qsr_ctrl (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            out_busy_i,
  output logic                            emit_o,
  output logic [qsr_pkg::ITER_BITS-1:0]   iterations_o,
  output logic [1:0]                      status_o,
  input  qsr_pkg::dp_stat_t               stat_i,
  output qsr_pkg::dp_cmd_t                cmd_o
);
  import qsr_pkg::*;

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CHECK  = 5'd1;
  localparam logic [4:0] S_PINIT  = 5'd2;
  localparam logic [4:0] S_PMUL   = 5'd3;
  localparam logic [4:0] S_PWAIT  = 5'd4;
  localparam logic [4:0] S_PQ     = 5'd5;
  localparam logic [4:0] S_PADD   = 5'd6;
  localparam logic [4:0] S_PSTORE = 5'd7;
  localparam logic [4:0] S_DIFF   = 5'd8;
  localparam logic [4:0] S_CHK1   = 5'd9;
  localparam logic [4:0] S_NMUL   = 5'd10;
  localparam logic [4:0] S_NWAIT  = 5'd11;
  localparam logic [4:0] S_DIVS   = 5'd12;
  localparam logic [4:0] S_DWAIT  = 5'd13;
  localparam logic [4:0] S_STEP   = 5'd14;
  localparam logic [4:0] S_UPD    = 5'd15;
  localparam logic [4:0] S_CHK2   = 5'd16;
  localparam logic [4:0] S_EMIT   = 5'd17;

  // Which polynomial value is being formed
  localparam logic [2:0] PH_F1  = 3'd0;
  localparam logic [2:0] PH_F0  = 3'd1;
  localparam logic [2:0] PH_FP  = 3'd2;
  localparam logic [2:0] PH_FM  = 3'd3;
  localparam logic [2:0] PH_RES = 3'd4;

  logic [4:0]               state_q, state_d;
  logic [2:0]               phase_q, phase_d;
  logic [COEF_IDX_BITS-1:0] k_q, k_d;
  logic [ITER_BITS-1:0]     it_q, it_d;
  logic [1:0]               status_q, status_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    k_d        = k_q;
    it_d       = it_q;
    status_d   = status_q;
    in_ready_o = 1'b0;
    emit_o     = 1'b0;
    cmd_o      = '{op: CMD_NONE, src: SRC_X1, coef_k: k_q, slot: SLOT_NONE};

    case (phase_q)
      PH_F0:   cmd_o.src = SRC_X0;
      PH_FP:   cmd_o.src = SRC_XP;
      PH_FM:   cmd_o.src = SRC_XM;
      default: cmd_o.src = SRC_X1;
    endcase

    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = CMD_LOAD;
          it_d     = '0;
          status_d = ST_LIMIT;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        if (it_q == stat_i.limit) begin
          phase_d = PH_RES;
        end else begin
          cmd_o.op = CMD_ITER;
          phase_d  = PH_F1;
        end
        state_d = S_PINIT;
      end
      // Horner evaluation at the point chosen by the phase
      S_PINIT: begin
        cmd_o.op = CMD_PSTART;
        k_d      = COEF_IDX_BITS'(1);
        state_d  = S_PMUL;
      end
      S_PMUL: begin
        cmd_o.op = CMD_MUL_START;
        state_d  = S_PWAIT;
      end
      S_PWAIT: begin
        if (!stat_i.mul_busy) begin
          state_d = S_PQ;
        end
      end
      S_PQ: begin
        cmd_o.op = CMD_MULQ;
        state_d  = S_PADD;
      end
      S_PADD: begin
        cmd_o.op = CMD_HORNER;
        if (k_q == COEF_IDX_BITS'(NUM_COEFS - 1)) begin
          state_d = S_PSTORE;
        end else begin
          k_d     = k_q + 1'b1;
          state_d = S_PMUL;
        end
      end
      S_PSTORE: begin
        cmd_o.op = CMD_STORE;
        case (phase_q)
          PH_F1: begin
            cmd_o.slot = SLOT_FA;
            phase_d    = stat_i.modified ? PH_FP : PH_F0;
            state_d    = S_PINIT;
          end
          PH_F0: begin
            cmd_o.slot = SLOT_FB;
            state_d    = S_DIFF;
          end
          PH_FP: begin
            cmd_o.slot = SLOT_FB;
            phase_d    = PH_FM;
            state_d    = S_PINIT;
          end
          PH_FM: begin
            cmd_o.slot = SLOT_FC;
            state_d    = S_DIFF;
          end
          default: state_d = S_EMIT;
        endcase
      end
      S_DIFF: begin
        cmd_o.op = CMD_DIFF;
        state_d  = S_CHK1;
      end
      S_CHK1: begin
        if (stat_i.ov) begin
          status_d = ST_OVERFLOW;
          phase_d  = PH_RES;
          state_d  = S_PINIT;
        end else if (stat_i.den_zero) begin
          status_d = ST_ZERO_DEN;
          phase_d  = PH_RES;
          state_d  = S_PINIT;
        end else begin
          state_d = S_NMUL;
        end
      end
      S_NMUL: begin
        cmd_o.op = CMD_NUM_START;
        state_d  = S_NWAIT;
      end
      S_NWAIT: begin
        if (!stat_i.mul_busy) begin
          state_d = S_DIVS;
        end
      end
      S_DIVS: begin
        cmd_o.op = CMD_DIV_START;
        state_d  = S_DWAIT;
      end
      S_DWAIT: begin
        if (!stat_i.div_busy) begin
          state_d = S_STEP;
        end
      end
      S_STEP: begin
        cmd_o.op = CMD_STEP;
        state_d  = S_UPD;
      end
      S_UPD: begin
        cmd_o.op = CMD_UPDATE;
        state_d  = S_CHK2;
      end
      S_CHK2: begin
        phase_d = PH_RES;
        if (stat_i.ov) begin
          status_d = ST_OVERFLOW;
          state_d  = S_PINIT;
        end else begin
          it_d = it_q + 1'b1;
          if (stat_i.conv) begin
            status_d = ST_CONVERGED;
            state_d  = S_PINIT;
          end else begin
            state_d = S_CHECK;
          end
        end
      end
      S_EMIT: begin
        if (!out_busy_i) begin
          emit_o  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      phase_q  <= PH_F1;
      k_q      <= '0;
      it_q     <= '0;
      status_q <= ST_LIMIT;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      k_q      <= k_d;
      it_q     <= it_d;
      status_q <= status_d;
    end
  end

  assign iterations_o = it_q;
  assign status_o     = status_q;

endmodule

### src/quartic_secant_root_finder_core.sv
// Top level of the quartic secant root finder: channels, output register, controller, datapath.
//
//  channel  dir  payload                                  transfer when
//  in_i     in   opcode, start_a, start_b                 valid && ready
//  out_o    out  root, residual, iterations, status       valid && ready
//  cfg_i    in   index (register number), data            valid && ready (ready always high)
//
// One request at a time. A polynomial value takes four multiplies, each made of four passes of
// one 32 x 32 multiplier, plus set-up and store. A classic iteration evaluates the polynomial
// twice and a modified one three times, and each also waits on the one-bit-per-cycle divider.
// Each request ends with one more polynomial evaluation for the residual.
// Reset clears the controller and loads the register defaults; no clearing pass.
// The result waits in an output register; a new request is taken while it waits.
`timescale 1ns / 1ps
module quartic_secant_root_finder_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  qsr_req_if.sink    in_i,
  qsr_res_if.source  out_o,
  qsr_cfg_if.sink    cfg_i
);
  import qsr_pkg::*;

  dp_cmd_t               cmd;
  dp_stat_t              stat;
  word_t                 root, residual;
  logic                  emit, out_busy, out_valid_q;
  logic [ITER_BITS-1:0]  iterations;
  logic [1:0]            status;
  word_t                 root_q, residual_q;
  logic [ITER_BITS-1:0]  iterations_q;
  logic [1:0]            status_q;

  assign cfg_i.ready = 1'b1;
  assign out_busy    = out_valid_q && !out_o.ready;

  qsr_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .out_busy_i   (out_busy),
    .emit_o       (emit),
    .iterations_o (iterations),
    .status_o     (status),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  qsr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_i.valid),
    .cfg_idx_i  (cfg_i.index),
    .cfg_data_i (cfg_i.data),
    .opcode_i   (in_i.opcode),
    .start_a_i  (in_i.start_a),
    .start_b_i  (in_i.start_b),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .root_o     (root),
    .residual_o (residual)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      root_q       <= root;
      residual_q   <= residual;
      iterations_q <= iterations;
      status_q     <= status;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.root       = root_q;
  assign out_o.residual   = residual_q;
  assign out_o.iterations = iterations_q;
  assign out_o.status     = status_q;

endmodule

### src/qsr_checker.sv
// Port-level checks for the quartic secant root finder, bound to the top level.
`timescale 1ns / 1ps
module qsr_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_i,
  input logic                          out_valid_i,
  input logic                          out_ready_i,
  input qsr_pkg::word_t                out_root_i,
  input logic [qsr_pkg::ITER_BITS-1:0] out_iterations_i,
  input logic [1:0]                    out_status_i
);
  import qsr_pkg::*;

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_root_i)
      && $stable(out_status_i) && $stable(out_iterations_i))
    else $error("result changed while stalled");

  // Convergence needs at least one update
  a_conv_iter: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i == ST_CONVERGED) |-> out_iterations_i != '0)
    else $error("converged with no iterations");

  // The block is busy right after taking a request
  a_busy_after: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while busy");

  // No result appears in the cycle after a request transfer
  a_no_instant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !$rose(out_valid_i))
    else $error("result too early");

endmodule

bind quartic_secant_root_finder_core qsr_checker u_qsr_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (in_i.valid),
  .in_ready_i       (in_i.ready),
  .out_valid_i      (out_o.valid),
  .out_ready_i      (out_o.ready),
  .out_root_i       (out_o.root),
  .out_iterations_i (out_o.iterations),
  .out_status_i     (out_o.status)
);
